// ===== rtl/prefix_expression_stack_evaluator_core_macros.svh =====
// assertion helpers for the prefix expression evaluator
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_MACROS_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define PESE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define PESE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pese_pkg.sv =====
package pese_pkg;

	localparam int DATA_W          = 32;
	localparam int ITER_W          = $clog2(DATA_W);
	localparam int DEF_STACK_DEPTH = 16;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// ascii characters of interest
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;

	// operator codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} sym_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [2:0]               status;
	} res_item_t;

endpackage

// ===== rtl/pese_chan_if.sv =====
interface pese_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/pese_ram.sv =====
module pese_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/prefix_expression_stack_evaluator_core.sv =====
// prefix expression evaluator with an operand stack in a small ram
// symbols channel: one ascii character per request, sent right to left;
//   last marks the leftmost character and closes the expression
// results channel: one request per expression with the top of the stack
//   (0 if empty) and a status: ok, underflow, divide by zero, stack full,
//   or empty at end; the first error of an expression is the one reported
// steps per character, from acceptance to the next acceptance: a digit
//   or ignored character is taken in idle; + - * do two ram reads,
//   operand load, execute, write back; / runs the 32-step restoring
//   divide on the one shared adder (two ram reads, operand load, sign
//   fix-ups, 32 steps, write back); last adds the top-of-stack ram read
// symbols.ready is high only while the sequencer is idle
// the result sits in an output register; a stalled receiver holds it while
//   further characters are accepted; a second result waits in the final
//   state until the register frees
// reset clears the stack count, the sticky error and the output valid;
//   the stack ram is not cleared since no entry is read before it is written
`include "prefix_expression_stack_evaluator_core_macros.svh"

module prefix_expression_stack_evaluator_core #(
	parameter int STACK_DEPTH = pese_pkg::DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	pese_chan_if.sink   symbols,
	pese_chan_if.source results
);
	import pese_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_LDB  = 4'd3;
	localparam logic [3:0] S_EXEC = 4'd4;
	localparam logic [3:0] S_NEGN = 4'd5;
	localparam logic [3:0] S_NEGD = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIX  = 4'd8;
	localparam logic [3:0] S_WB   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;
	localparam logic [3:0] S_FRD  = 4'd11;

	function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	// control registers
	logic [3:0]        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [2:0]        err_q, err_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic [1:0]        op_q, op_d;
	logic              last_q, last_d;
	logic              res_valid_q;

	// datapath registers
	logic [DATA_W-1:0] a_q;      // top operand, later dividend and quotient
	logic [DATA_W-1:0] b_q;      // second operand, later divisor magnitude
	logic [DATA_W-1:0] rem_q;    // partial remainder
	logic [DATA_W-1:0] r_q;      // result to push
	logic              neg_q;    // quotient sign
	logic [DATA_W-1:0] value_q;
	logic [2:0]        status_q;

	// shared adder
	logic [DATA_W-1:0] add_x, add_y;
	logic              add_cin;
	logic [DATA_W:0]   sum_w;
	logic              carry;

	logic [DATA_W-1:0] mul_lo;

	// stack ram port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic [7:0]    sym;
	logic          is_digit, is_op, accept, out_free, load_res;
	logic [1:0]    sym_op;
	logic [CW-1:0] cnt_m1, cnt_m2;

	assign sym      = symbols.payload.symbol;
	assign accept   = symbols.valid && symbols.ready;
	assign out_free = !res_valid_q || results.ready;
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);

	assign symbols.ready          = (state_q == S_IDLE);
	assign results.valid          = res_valid_q;
	assign results.payload.value  = value_q;
	assign results.payload.status = status_q;

	// decode one character
	always_comb begin
		is_digit = sym inside {[SYM_ZERO:SYM_NINE]};
		is_op    = 1'b1;
		sym_op   = OP_ADD;
		case (sym)
			SYM_ADD: sym_op = OP_ADD;
			SYM_SUB: sym_op = OP_SUB;
			SYM_MUL: sym_op = OP_MUL;
			SYM_DIV: sym_op = OP_DIV;
			default: is_op = 1'b0;
		endcase
	end

	assign sum_w  = {1'b0, add_x} + {1'b0, add_y} + (DATA_W + 1)'(add_cin);
	assign carry  = sum_w[DATA_W];
	assign mul_lo = a_q * b_q;

	// sequencer and shared-adder operand select
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		err_d     = err_q;
		iter_d    = iter_q;
		op_d      = op_q;
		last_d    = last_q;
		load_res  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = r_q;
		ram_raddr = cnt_m1[AW-1:0];
		add_x     = a_q;
		add_y     = b_q;
		add_cin   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					last_d  = symbols.payload.last;
					state_d = symbols.payload.last ? S_FIN : S_IDLE;
					if (is_op) begin
						op_d = sym_op;
						if (cnt_q < CW'(2)) begin
							err_d = first_err(err_q, ST_UNDERFLOW);
						end else begin
							state_d = S_RDA;
						end
					end else if (is_digit) begin
						if (cnt_q == CW'(STACK_DEPTH)) begin
							err_d = first_err(err_q, ST_FULL);
						end else begin
							ram_we    = 1'b1;
							ram_wdata = DATA_W'(sym[3:0]);
							cnt_d     = cnt_q + CW'(1);
						end
					end
				end
			end
			S_RDA: begin
				state_d = S_RDB;
			end
			S_RDB: begin
				ram_raddr = cnt_m2[AW-1:0];
				state_d   = S_LDB;
			end
			S_LDB: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_WB;
				if (op_q == OP_SUB) begin
					add_y   = ~b_q;
					add_cin = 1'b1;
				end
				if (op_q == OP_DIV) begin
					if (b_q == '0) begin
						err_d = first_err(err_q, ST_DIVZERO);
					end else begin
						state_d = S_NEGN;
					end
				end
			end
			S_NEGN: begin
				add_x   = '0;
				add_y   = ~a_q;
				add_cin = 1'b1;
				state_d = S_NEGD;
			end
			S_NEGD: begin
				add_x   = '0;
				add_y   = ~b_q;
				add_cin = 1'b1;
				iter_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				// one restoring step: trial subtract of the divisor
				add_x   = {rem_q[DATA_W-2:0], a_q[DATA_W-1]};
				add_y   = ~b_q;
				add_cin = 1'b1;
				iter_d  = iter_q + ITER_W'(1);
				if (iter_q == ITER_LAST) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				add_x   = '0;
				add_y   = ~a_q;
				add_cin = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				// result replaces the two operands
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[AW-1:0];
				cnt_d     = cnt_q - CW'(1);
				state_d   = last_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				state_d = S_FRD;
			end
			S_FRD: begin
				if (out_free) begin
					load_res = 1'b1;
					cnt_d    = '0;
					err_d    = ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			iter_q      <= '0;
			op_q        <= OP_ADD;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			iter_q  <= iter_d;
			op_q    <= op_d;
			last_q  <= last_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// operand, divider and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_RDB: a_q <= ram_rdata;
			S_LDB: b_q <= ram_rdata;
			S_EXEC: begin
				neg_q <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
				rem_q <= '0;
				case (op_q)
					OP_ADD, OP_SUB: r_q <= sum_w[DATA_W-1:0];
					OP_MUL:         r_q <= mul_lo;
					default:        r_q <= '0;
				endcase
			end
			S_NEGN: begin
				if (a_q[DATA_W-1]) begin
					a_q <= sum_w[DATA_W-1:0];
				end
			end
			S_NEGD: begin
				if (b_q[DATA_W-1]) begin
					b_q <= sum_w[DATA_W-1:0];
				end
			end
			S_DIV: begin
				rem_q <= carry ? sum_w[DATA_W-1:0] : add_x;
				a_q   <= {a_q[DATA_W-2:0], carry};
			end
			S_FIX: r_q <= neg_q ? sum_w[DATA_W-1:0] : a_q;
			default: ;
		endcase
		if (load_res) begin
			value_q <= (cnt_q == '0) ? '0 : ram_rdata;
			if (err_q != ST_OK) begin
				status_q <= err_q;
			end else if (cnt_q == '0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	pese_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`PESE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`PESE_ASSERT_NOW(a_wb_operands, state_q == S_WB, cnt_q >= CW'(2), "write back without two operands")
	`PESE_ASSERT_NEXT(a_div_exit, (state_q == S_DIV) && (iter_q == ITER_LAST), state_q == S_FIX, "divide loop did not finish")
	`PESE_ASSERT_NOW(a_res_clears, $rose(res_valid_q), (cnt_q == '0) && (err_q == ST_OK), "stack or error not cleared after result")

endmodule
